[rtl/core/swp_pkg.sv]
`default_nettype none

package swp_pkg;

    localparam int DEF_SEG_DEPTH = 256;
    localparam int DEF_SEQ_SLOTS = 30;
    localparam int DEF_SEGMENTS  = 4;

    localparam logic [11:0] RESET_CODE = 12'd2037;
    localparam int          RESET_LEN  = 200;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_LEN   = 3'd1;
    localparam logic [2:0] CMD_SLOT  = 3'd2;
    localparam logic [2:0] CMD_TRIG  = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    typedef struct packed {
        logic [11:0] dac_code;
        logic        dac_write;
        logic        last_sample;
        logic        busy_res;
        logic        rejected;
    } t_res;

endpackage

`default_nettype wire

[rtl/core/swp_ram.sv]
`default_nettype none

module swp_ram #(
    parameter int WIDTH  = 12,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/swp_obuf.sv]
`default_nettype none

module swp_obuf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire swp_pkg::t_res i_res,
    output logic               o_free,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [15:0]        m_axis_tdata,  // dac_code[11:0], busy_res, rejected, zero pad
    output logic               m_axis_tuser,  // dac_write
    output logic               m_axis_tlast   // last_sample
);

    logic          r_valid;
    swp_pkg::t_res r_res;

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_res.rejected, r_res.busy_res, r_res.dac_code};
    assign m_axis_tuser  = r_res.dac_write;
    assign m_axis_tlast  = r_res.last_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sequenced_waveform_playback.sv]
`default_nettype none

// channel   | dir | width           | contents
// s_axis    | in  | tdata 40, user 3| request: command in tuser, operands in tdata
// m_axis    | out | tdata 16, user 1| one result per request, tlast on final sample
//
// write, length, slot, trigger and idle requests are answered straight from the idle state
// a tick during playback goes through a slot memory read, then a sample memory read
// after reset a clearing pass over max(SEGMENTS*SEG_DEPTH, SEQ_SLOTS) addresses
// (1024 by default) fills both memories before the first request is taken
// a stalled output holds its result; one further result waits internally

module sequenced_waveform_playback #(
    parameter int SEG_DEPTH = swp_pkg::DEF_SEG_DEPTH,
    parameter int SEQ_SLOTS = swp_pkg::DEF_SEQ_SLOTS,
    parameter int SEGMENTS  = swp_pkg::DEF_SEGMENTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // segment[1:0], sample_index[9:2],
                                            // sample_code[21:10], seg_length[30:22],
                                            // seq_slot[35:31], zero pad
    input  wire logic [2:0]  s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // dac_code[11:0], busy_res, rejected, zero pad
    output logic             m_axis_tuser,  // dac_write
    output logic             m_axis_tlast   // last_sample
);

    localparam int NSAMP = SEGMENTS * SEG_DEPTH;
    localparam int CLR_N = (NSAMP > SEQ_SLOTS) ? NSAMP : SEQ_SLOTS;
    localparam int AW    = (NSAMP > 1) ? $clog2(NSAMP) : 1;
    localparam int SLW   = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
    localparam int SGW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int PW    = $clog2(SEG_DEPTH);
    localparam int LW    = $clog2(SEG_DEPTH + 1);
    localparam int CW    = $clog2(CLR_N);
    localparam int RLEN  = (swp_pkg::RESET_LEN > SEG_DEPTH) ? SEG_DEPTH : swp_pkg::RESET_LEN;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_SAMP,
        S_HOLD
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_clr;
    logic          r_playing;
    logic [SLW-1:0] r_slot_ptr;
    logic [PW-1:0] r_samp_ptr;
    logic [LW-1:0] r_seglen;
    logic [LW-1:0] r_seg_len [SEGMENTS];
    swp_pkg::t_res r_res;

    logic [2:0]  w_cmd;
    logic [1:0]  w_seg;
    logic [7:0]  w_idx;
    logic [11:0] w_code;
    logic [8:0]  w_len;
    logic [4:0]  w_slot;
    logic        w_acc;
    logic        w_seg_ok;
    logic        w_tick_play;

    logic          w_samp_we;
    logic [AW-1:0] w_samp_waddr;
    logic [11:0]   w_samp_wdata;
    logic [AW-1:0] w_samp_raddr;
    logic [11:0]   w_samp_rdata;
    logic          w_slot_we;
    logic [SLW-1:0] w_slot_waddr;
    logic [SGW-1:0] w_slot_wdata;
    logic [SGW-1:0] w_slot_rdata;

    logic [LW-1:0] w_ptr_inc;
    logic          w_seg_end;
    logic          w_seq_end;
    swp_pkg::t_res w_res_idle;
    swp_pkg::t_res w_res_tick;
    swp_pkg::t_res w_res;
    logic          w_res_rdy;
    logic          w_free;
    logic          w_load;

    function automatic logic [LW-1:0] clamp_len(input logic [8:0] v);
        logic [LW-1:0] r;
        if (v == 9'd0) begin
            r = LW'(1);
        end else if (32'(v) > SEG_DEPTH) begin
            r = LW'(SEG_DEPTH);
        end else begin
            r = LW'(v);
        end
        return r;
    endfunction

    assign w_cmd  = s_axis_tuser;
    assign w_seg  = s_axis_tdata[1:0];
    assign w_idx  = s_axis_tdata[9:2];
    assign w_code = s_axis_tdata[21:10];
    assign w_len  = s_axis_tdata[30:22];
    assign w_slot = s_axis_tdata[35:31];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_seg_ok      = 32'(w_seg) < SEGMENTS;
    assign w_tick_play   = (w_cmd == swp_pkg::CMD_TICK) && r_playing;

    // memory ports: clearing pass, else request writes
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_samp_we    = 32'(r_clr) < NSAMP;
            w_samp_waddr = AW'(r_clr);
            w_samp_wdata = swp_pkg::RESET_CODE;
            w_slot_we    = 32'(r_clr) < SEQ_SLOTS;
            w_slot_waddr = SLW'(r_clr);
            w_slot_wdata = '0;
        end else begin
            w_samp_we    = w_acc && !r_playing && (w_cmd == swp_pkg::CMD_WRITE)
                           && w_seg_ok && (32'(w_idx) < SEG_DEPTH);
            w_samp_waddr = AW'(AW'(SGW'(w_seg)) * AW'(SEG_DEPTH) + AW'(w_idx));
            w_samp_wdata = w_code;
            w_slot_we    = w_acc && !r_playing && (w_cmd == swp_pkg::CMD_SLOT)
                           && w_seg_ok && (32'(w_slot) < SEQ_SLOTS);
            w_slot_waddr = SLW'(w_slot);
            w_slot_wdata = SGW'(w_seg);
        end
    end

    assign w_samp_raddr = AW'(AW'(w_slot_rdata) * AW'(SEG_DEPTH) + AW'(r_samp_ptr));

    swp_ram #(
        .WIDTH (12),
        .DEPTH (NSAMP)
    ) u_samp_ram (
        .i_clk   (i_clk),
        .i_we    (w_samp_we),
        .i_waddr (w_samp_waddr),
        .i_wdata (w_samp_wdata),
        .i_raddr (w_samp_raddr),
        .o_rdata (w_samp_rdata)
    );

    swp_ram #(
        .WIDTH (SGW),
        .DEPTH (SEQ_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr (r_slot_ptr),
        .o_rdata (w_slot_rdata)
    );

    // result of a non-tick or idle request
    always_comb begin
        w_res_idle          = '0;
        w_res_idle.busy_res = r_playing;
        if (r_playing && (w_cmd <= swp_pkg::CMD_TRIG)) begin
            w_res_idle.rejected = 1'b1;
        end else if (w_cmd == swp_pkg::CMD_TRIG) begin
            w_res_idle.busy_res = 1'b1;
        end
    end

    assign w_ptr_inc = LW'(r_samp_ptr) + LW'(1);
    assign w_seg_end = w_ptr_inc >= r_seglen;
    assign w_seq_end = w_seg_end && (32'(r_slot_ptr) == SEQ_SLOTS - 1);

    always_comb begin
        w_res_tick             = '0;
        w_res_tick.dac_code    = w_samp_rdata;
        w_res_tick.dac_write   = 1'b1;
        w_res_tick.last_sample = w_seq_end;
        w_res_tick.busy_res    = !w_seq_end;
    end

    always_comb begin
        w_res     = '0;
        w_res_rdy = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                w_res     = w_res_idle;
                w_res_rdy = w_acc && !w_tick_play;
            end
            S_SAMP: begin
                w_res     = w_res_tick;
                w_res_rdy = 1'b1;
            end
            S_HOLD: begin
                w_res     = r_res;
                w_res_rdy = 1'b1;
            end
            default: begin
                w_res     = '0;
                w_res_rdy = 1'b0;
            end
        endcase
    end

    assign w_load = w_res_rdy && w_free;

    swp_obuf u_obuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_res         (w_res),
        .o_free        (w_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_playing  <= 1'b0;
            r_slot_ptr <= '0;
            r_samp_ptr <= '0;
            for (int s = 0; s < SEGMENTS; s++) begin
                r_seg_len[s] <= LW'(RLEN);
            end
        end else begin
            if (w_res_rdy && !w_free) begin
                r_res <= w_res;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (32'(r_clr) == CLR_N - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        if (w_tick_play) begin
                            r_state <= S_SLOT;
                        end else begin
                            if (!w_free) begin
                                r_state <= S_HOLD;
                            end
                            if (!r_playing && (w_cmd == swp_pkg::CMD_LEN) && w_seg_ok) begin
                                r_seg_len[SGW'(w_seg)] <= clamp_len(w_len);
                            end
                            if (!r_playing && (w_cmd == swp_pkg::CMD_TRIG)) begin
                                r_playing  <= 1'b1;
                                r_slot_ptr <= '0;
                                r_samp_ptr <= '0;
                            end
                        end
                    end
                end
                S_SLOT: begin
                    r_seglen <= r_seg_len[w_slot_rdata];
                    r_state  <= S_SAMP;
                end
                S_SAMP: begin
                    if (w_seg_end) begin
                        r_samp_ptr <= '0;
                        if (w_seq_end) begin
                            r_slot_ptr <= '0;
                            r_playing  <= 1'b0;
                        end else begin
                            r_slot_ptr <= r_slot_ptr + SLW'(1);
                        end
                    end else begin
                        r_samp_ptr <= r_samp_ptr + PW'(1);
                    end
                    r_state <= w_free ? S_IDLE : S_HOLD;
                end
                S_HOLD: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[verif/sequenced_waveform_playback_tb.sv]
`default_nettype none

module sequenced_waveform_playback_tb;

    localparam int         DEPTH         = swp_pkg::DEF_SEG_DEPTH;
    localparam int         SLOTS         = swp_pkg::DEF_SEQ_SLOTS;
    localparam int         SEGS          = swp_pkg::DEF_SEGMENTS;
    localparam logic [2:0] CMD_MAX       = 3'd7;
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         TOTAL_ITEMS   = 1950;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // segment, sample_index, sample_code, seg_length, seq_slot
    logic [2:0]  s_axis_tuser  = '0;  // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // dac_code, busy_res, rejected
    logic        m_axis_tuser;        // dac_write
    logic        m_axis_tlast;        // last_sample

    // own copy of the player state
    logic [11:0] stored_codes [SEGS][DEPTH];
    logic [8:0]  seg_len [SEGS];
    logic [1:0]  slot_seg [SLOTS];
    bit          model_playing;
    int          model_slot;
    int          model_sample;

    swp_pkg::t_res playback_expect [$];
    swp_pkg::t_res want_res;

    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int samples_played = 0;
    int sequences_done = 0;
    int rejects_seen   = 0;
    int burst_left     = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int rx_hold_left   = 0;
    int rx_cycle       = 0;
    int cycle_count    = 0;

    sequenced_waveform_playback DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     playback_expect.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic swp_pkg::t_res predict_playback(input logic [2:0] cmd,
                                                       input logic [1:0] seg,
                                                       input logic [7:0] idx,
                                                       input logic [11:0] code,
                                                       input logic [8:0] len,
                                                       input logic [4:0] slot);
        swp_pkg::t_res r;
        logic [1:0]    cur_seg;
        r = '0;
        if (cmd <= swp_pkg::CMD_TRIG && model_playing) begin
            r.rejected = 1'b1;
        end else begin
            case (cmd)
                swp_pkg::CMD_WRITE: stored_codes[seg][idx] = code;
                swp_pkg::CMD_LEN:
                    seg_len[seg] = (len == 0) ? 9'd1 : (len > DEPTH) ? 9'(DEPTH) : len;
                swp_pkg::CMD_SLOT:  if (slot < SLOTS) slot_seg[slot] = seg;
                swp_pkg::CMD_TRIG: begin
                    model_playing = 1'b1;
                    model_slot    = 0;
                    model_sample  = 0;
                end
                swp_pkg::CMD_TICK: if (model_playing) begin
                    cur_seg     = slot_seg[model_slot];
                    r.dac_code  = stored_codes[cur_seg][model_sample];
                    r.dac_write = 1'b1;
                    model_sample++;
                    if (model_sample >= seg_len[cur_seg]) begin
                        model_sample = 0;
                        model_slot++;
                        if (model_slot >= SLOTS) begin
                            model_slot    = 0;
                            model_playing = 1'b0;
                            r.last_sample = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.busy_res = model_playing;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got,
                 want);
        mismatches++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (playback_expect.size() == 0) begin
                report_mismatch("result with no request pending", 1, 0);
            end else begin
                want_res = playback_expect.pop_front();
                if (m_axis_tdata[11:0] !== want_res.dac_code)
                    report_mismatch("dac_code", m_axis_tdata[11:0], want_res.dac_code);
                if (m_axis_tuser !== want_res.dac_write)
                    report_mismatch("dac_write", m_axis_tuser, want_res.dac_write);
                if (m_axis_tlast !== want_res.last_sample)
                    report_mismatch("last_sample", m_axis_tlast, want_res.last_sample);
                if (m_axis_tdata[12] !== want_res.busy_res)
                    report_mismatch("busy_res", m_axis_tdata[12], want_res.busy_res);
                if (m_axis_tdata[13] !== want_res.rejected)
                    report_mismatch("rejected", m_axis_tdata[13], want_res.rejected);
                if (m_axis_tdata[15:14] !== 2'b00)
                    report_mismatch("tdata pad", m_axis_tdata[15:14], 0);
                samples_played += want_res.dac_write;
                sequences_done += want_res.last_sample;
                rejects_seen   += want_res.rejected;
            end
            results_seen++;
        end
    end

    // output stall pattern, plus long hold-offs on request
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_requests != hold_served) begin
            hold_served   <= hold_requests;
            rx_hold_left  <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 300) % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       m_axis_tready <= ((rx_cycle % 7) < 2);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_req(input logic [2:0] cmd, input logic [1:0] seg, input logic [7:0] idx,
                            input logic [11:0] code, input logic [8:0] len,
                            input logic [4:0] slot);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, slot, len, code, idx, seg};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        playback_expect.push_back(predict_playback(cmd, seg, idx, code, len, slot));
        items_sent++;
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        send_req(cmd, 2'($urandom), 8'($urandom), 12'($urandom), 9'($urandom), 5'($urandom));
    endtask

    function automatic logic [8:0] pick_length();
        if ($urandom_range(0, 19) == 0) return 9'd0;
        if ($urandom_range(0, 9) == 0) return 9'($urandom_range(7, 24));
        return 9'($urandom_range(1, 6));
    endfunction

    // ticks until the sequence ends, mixed with rejected and unknown requests
    task automatic drain_playback(input int noise_pct);
        int r;
        while (model_playing) begin
            r = $urandom_range(0, 99);
            if (r < noise_pct / 3)
                send_cmd(3'($urandom_range(swp_pkg::CMD_TICK + 1, CMD_MAX)));
            else if (r < noise_pct)
                send_cmd(3'($urandom_range(swp_pkg::CMD_WRITE, swp_pkg::CMD_TRIG)));
            else
                send_cmd(swp_pkg::CMD_TICK);
        end
    endtask

    task automatic test_idle_commands();
        send_cmd(swp_pkg::CMD_TICK);
        for (int c = swp_pkg::CMD_TICK + 1; c <= CMD_MAX; c++) send_cmd(3'(c));
        send_cmd(swp_pkg::CMD_TICK);
    endtask

    // segment 0 keeps its default length and codes in slot 0
    task automatic test_reset_defaults();
        send_req(swp_pkg::CMD_LEN, 2'd1, 8'd0, 12'd0, 9'd1, 5'd0);
        for (int s = 1; s < SLOTS; s++)
            send_req(swp_pkg::CMD_SLOT, 2'd1, 8'd0, 12'd0, 9'd0, 5'(s));
        send_cmd(swp_pkg::CMD_TRIG);
        drain_playback(0);
    endtask

    task automatic test_field_extremes();
        logic [1:0] seg;
        send_req(swp_pkg::CMD_LEN, 2'd0, 8'd0, 12'd0, 9'd0, 5'd0);
        send_req(swp_pkg::CMD_LEN, 2'd1, 8'd0, 12'd0, 9'd256, 5'd0);
        send_req(swp_pkg::CMD_LEN, 2'd2, 8'hFF, 12'hFFF, 9'd511, 5'd31);
        send_req(swp_pkg::CMD_LEN, 2'd3, 8'd0, 12'd0, 9'd2, 5'd0);
        send_req(swp_pkg::CMD_WRITE, 2'd1, 8'hFF, 12'hFFF, 9'd0, 5'd0);
        send_req(swp_pkg::CMD_WRITE, 2'd1, 8'h00, 12'h000, 9'h1FF, 5'h1F);
        send_req(swp_pkg::CMD_WRITE, 2'd2, 8'hFF, 12'hAAA, 9'd0, 5'd0);
        send_req(swp_pkg::CMD_WRITE, 2'd3, 8'h01, 12'h555, 9'd0, 5'd0);
        for (int s = 0; s < SLOTS; s++) begin
            seg = (s == 5) ? 2'd1 : (s == SLOTS - 1) ? 2'd2 : (s % 2 == 1) ? 2'd3 : 2'd0;
            send_req(swp_pkg::CMD_SLOT, seg, 8'd0, 12'd0, 9'd0, 5'(s));
        end
        // slot positions past the table
        send_req(swp_pkg::CMD_SLOT, 2'd3, 8'd0, 12'd0, 9'd0, 5'd30);
        send_req(swp_pkg::CMD_SLOT, 2'd1, 8'd0, 12'd0, 9'd0, 5'd31);
        send_cmd(swp_pkg::CMD_TRIG);
        send_cmd(swp_pkg::CMD_TICK);
        for (int c = swp_pkg::CMD_WRITE; c <= swp_pkg::CMD_TRIG; c++) send_cmd(3'(c));
        for (int c = swp_pkg::CMD_TICK + 1; c <= CMD_MAX; c++) send_cmd(3'(c));
        drain_playback(0);
    endtask

    task automatic test_back_pressure();
        for (int s = 0; s < SEGS; s++)
            send_req(swp_pkg::CMD_LEN, 2'(s), 8'd0, 12'd0, 9'd3, 5'd0);
        send_cmd(swp_pkg::CMD_TRIG);
        hold_requests++;
        drain_playback(10);
    endtask

    task automatic test_random_sequences(input int target);
        int style;
        while (items_sent < target) begin
            style = $urandom_range(0, 9);
            if (style == 0) begin
                repeat ($urandom_range(1, 5))
                    send_cmd(($urandom_range(0, 1) == 0) ? swp_pkg::CMD_TICK
                             : 3'($urandom_range(swp_pkg::CMD_TICK + 1, CMD_MAX)));
            end else begin
                repeat ($urandom_range(0, 4))
                    send_req(swp_pkg::CMD_LEN, 2'($urandom), 8'($urandom), 12'($urandom),
                             pick_length(), 5'($urandom));
                repeat ($urandom_range(0, 12))
                    send_req(swp_pkg::CMD_SLOT, 2'($urandom), 8'($urandom), 12'($urandom),
                             9'($urandom), 5'($urandom));
                repeat ($urandom_range(0, 10))
                    send_req(swp_pkg::CMD_WRITE, 2'($urandom),
                             ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 7)),
                             12'($urandom), 9'($urandom), 5'($urandom));
                send_cmd(swp_pkg::CMD_TRIG);
                if (style == 1) send_cmd(swp_pkg::CMD_TRIG);
                drain_playback((style == 2) ? 30 : 8);
            end
        end
    endtask

    initial begin
        for (int g = 0; g < SEGS; g++) begin
            seg_len[g] = 9'(swp_pkg::RESET_LEN);
            for (int i = 0; i < DEPTH; i++) stored_codes[g][i] = swp_pkg::RESET_CODE;
        end
        for (int s = 0; s < SLOTS; s++) slot_seg[s] = '0;
        model_playing = 1'b0;
        model_slot    = 0;
        model_sample  = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_reset_defaults();
        test_field_extremes();
        test_back_pressure();
        test_random_sequences(TOTAL_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (playback_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests checked, %0d samples over %0d full sequences, %0d rejected",
                 items_sent, samples_played, sequences_done, rejects_seen);
        $display("lengths 0 to 511, out-of-range slots, idle ticks, unknown commands and a %0d%s",
                 HOLD_CYCLES, "-cycle output hold-off");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/core/swp_pkg.sv
rtl/core/swp_ram.sv
rtl/core/swp_obuf.sv
rtl/core/sequenced_waveform_playback.sv
verif/sequenced_waveform_playback_tb.sv
